@@ hw/rtl/kpsm_pkg.sv @@
// Package for the key pair sequence matcher.
// Holds defaults, register indexes and the match/status codes; depends on nothing.
package kpsm_pkg;

  localparam int unsigned PairsDef     = 4;
  localparam int unsigned KeyBitsDef   = 32;
  localparam int unsigned KeyW         = 32;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 64;
  localparam int unsigned TimeoutW     = 32;
  localparam int unsigned CountW       = 3;
  localparam int unsigned StatusW      = 3;
  localparam int unsigned OutTdataW    = 8;
  localparam logic [TimeoutW-1:0] TimeoutReset = 32'd2000000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENABLE    = 3'd0,
    REG_TIMEOUT   = 3'd1,
    REG_COUNT     = 3'd2,
    REG_PATTERN_0 = 3'd3,
    REG_PATTERN_1 = 3'd4,
    REG_PATTERN_2 = 3'd5,
    REG_PATTERN_3 = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MATCH_NONE      = 2'd0,
    MATCH_PRIMARY   = 2'd1,
    MATCH_SECONDARY = 2'd2
  } match_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_NONE        = 3'd0,
    STATUS_PRIMARY     = 3'd1,
    STATUS_SECONDARY   = 3'd2,
    STATUS_NOT_INIT    = 3'd3,
    STATUS_NOT_ENABLED = 3'd4
  } status_e;

endpackage

@@ hw/rtl/key_pair_sequence_matcher.sv @@
// Key pair sequence matcher: top level with input stage, match logic and result register.
// Depends on kpsm_pkg.
//
// Takes one key press or time tick per cycle and returns one match status for each.
// A transaction sits in the input register, is evaluated against the configured pairs and
// the window state combinationally, and lands in the result register; throughput is one
// transaction per cycle while the output does not stall. While a result waits on the
// output, an empty input register still takes one transaction; once both registers are
// full, an output stall stalls the input in the same cycle. The rate is set by the PAIRS
// parallel key comparators and the 32-bit window counter update, which lie together
// between the input and result registers. Configuration is written through the plain
// write port while no transaction is in flight, which the user, not the block, ensures.
module key_pair_sequence_matcher
  import kpsm_pkg::*;
#(
  parameter int unsigned PAIRS    = PairsDef,
  parameter int unsigned KEY_BITS = KeyBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [KeyW-1:0]      s_axis_tdata,   // [31:0] key_code
  input  logic                 s_axis_tuser,   // [0] func (0 key press, 1 tick)
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata    // [2:0] match_status, [7:3] zero
);

  localparam logic [CountW-1:0] PairsC = CountW'(PAIRS);

  // configuration registers
  logic                enable_q;
  logic [TimeoutW-1:0] timeout_q;
  logic [CountW-1:0]   count_q;
  logic [KEY_BITS-1:0] prim_q [PAIRS];
  logic [KEY_BITS-1:0] sec_q  [PAIRS];

  // input stage
  logic                in_valid_q;
  logic                in_tick_q;
  logic [KEY_BITS-1:0] in_key_q;

  // matcher state
  match_e              match_q, match_d;
  logic [PAIRS-1:0]    wait_q, wait_d;
  logic [TimeoutW-1:0] win_cnt_q, win_cnt_d;
  logic                win_run_q, win_run_d;

  // result stage
  logic                out_valid_q;
  status_e             status_q, status_d;

  logic                advance;
  logic                fire;
  logic [CountW-1:0]   n_valid;
  logic [PAIRS-1:0]    prim_hits;
  logic                sec_hit;

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdataW - StatusW){1'b0}}, status_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b1;
      timeout_q <= TimeoutReset;
      count_q   <= '0;
      for (int i = 0; i < PAIRS; i++) begin
        prim_q[i] <= '0;
        sec_q[i]  <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_ENABLE) enable_q <= cfg_wdata_i[0];
      if (cfg_idx_i == REG_TIMEOUT) timeout_q <= cfg_wdata_i[TimeoutW-1:0];
      if (cfg_idx_i == REG_COUNT) count_q <= cfg_wdata_i[CountW-1:0];
      for (int i = 0; i < PAIRS; i++) begin
        if (cfg_idx_i == CfgIdxW'(REG_PATTERN_0) + CfgIdxW'(i)) begin
          prim_q[i] <= cfg_wdata_i[KeyW +: KEY_BITS];
          sec_q[i]  <= cfg_wdata_i[KEY_BITS-1:0];
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_tick_q <= s_axis_tuser;
      in_key_q  <= s_axis_tdata[KEY_BITS-1:0];
    end
  end

  // pair comparisons, limited to the effective pair count
  assign n_valid = (count_q > PairsC) ? PairsC : count_q;

  always_comb begin
    prim_hits = '0;
    sec_hit   = 1'b0;
    for (int i = 0; i < PAIRS; i++) begin
      if (CountW'(i) < n_valid) begin
        prim_hits[i] = (prim_q[i] == in_key_q);
        if (wait_q[i] && (sec_q[i] == in_key_q)) sec_hit = 1'b1;
      end
    end
  end

  always_comb begin
    match_d   = match_q;
    wait_d    = wait_q;
    win_cnt_d = win_cnt_q;
    win_run_d = win_run_q;
    status_d  = status_e'({1'b0, match_q});
    if (in_tick_q) begin
      if (win_run_q) begin
        if (win_cnt_q[TimeoutW-1:1] == '0) begin
          // window expired: drop the pending primary
          match_d   = MATCH_NONE;
          wait_d    = '0;
          win_cnt_d = '0;
          win_run_d = 1'b0;
        end else begin
          win_cnt_d = win_cnt_q - TimeoutW'(1);
        end
      end
      status_d = status_e'({1'b0, match_d});
    end else if (!enable_q) begin
      status_d = STATUS_NOT_ENABLED;
    end else if (n_valid == '0) begin
      status_d = STATUS_NOT_INIT;
    end else begin
      if (match_q == MATCH_PRIMARY && sec_hit) begin
        match_d   = MATCH_SECONDARY;
        wait_d    = '0;
        win_cnt_d = '0;
        win_run_d = 1'b0;
      end else if (prim_hits != '0) begin
        // arm every pair sharing this primary and restart the window
        match_d   = MATCH_PRIMARY;
        wait_d    = prim_hits;
        win_cnt_d = timeout_q;
        win_run_d = 1'b1;
      end else begin
        match_d   = MATCH_NONE;
        wait_d    = '0;
        win_cnt_d = '0;
        win_run_d = 1'b0;
      end
      status_d = status_e'({1'b0, match_d});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q   <= MATCH_NONE;
      wait_q    <= '0;
      win_cnt_q <= '0;
      win_run_q <= 1'b0;
    end else if (fire) begin
      match_q   <= match_d;
      wait_q    <= wait_d;
      win_cnt_q <= win_cnt_d;
      win_run_q <= win_run_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) status_q <= status_d;
  end

  // the window runs exactly while a primary match is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_run_q == (match_q == MATCH_PRIMARY))
    else $error("window running flag out of step with match state");

  // a pending primary always has at least one awaited secondary
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_run_q |-> (wait_q != '0))
    else $error("window running with empty waiting set");

  // a key press only gives a secondary match after a pending primary
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !in_tick_q && status_d == STATUS_SECONDARY) |-> (match_q == MATCH_PRIMARY))
    else $error("secondary match without pending primary");

  // an evaluated transaction always shows up as a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("evaluated transaction lost before result register");

endmodule

@@ sim/key_pair_sequence_matcher_tb.sv @@
// Testbench for key_pair_sequence_matcher: directed and random key/tick streams with
// random stalls on both stream sides, checked against an in-bench match predictor.
// Depends on kpsm_pkg and the key_pair_sequence_matcher RTL.
`timescale 1ns / 1ps

module key_pair_sequence_matcher_tb;
  import kpsm_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [KeyW-1:0]      s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;

  key_pair_sequence_matcher dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("[key_pair_sequence_matcher] ERROR");
    $finish;
  end

  // predictor copy of configuration and matcher state
  bit                  p_enable  = 1'b1;
  logic [TimeoutW-1:0] p_timeout = TimeoutReset;
  logic [CountW-1:0]   p_count   = '0;
  logic [63:0]         p_pair [4] = '{default: '0};
  match_e              m_state = MATCH_NONE;
  logic [3:0]          m_wait  = '0;
  logic [31:0]         m_win   = '0;
  bit                  m_run   = 1'b0;

  status_e exp_status_q [$];
  int      err_count = 0;
  bit      tx_gap_en = 1'b1;
  bit      rx_stall_en = 1'b1;
  int      rx_hold_cycles = 0;

  localparam bit EvKey  = 1'b0;
  localparam bit EvTick = 1'b1;

  function automatic void clear_window();
    m_state = MATCH_NONE;
    m_wait  = '0;
    m_win   = '0;
    m_run   = 1'b0;
  endfunction

  // Advance the predicted matcher by one event and return its status.
  function automatic status_e next_match_status(bit func, logic [31:0] key);
    int        n;
    logic [3:0] prim;
    bit        sec;
    prim = '0;
    sec  = 1'b0;
    if (func == EvTick) begin
      if (m_run) begin
        if (m_win <= 32'd1) clear_window();
        else m_win = m_win - 32'd1;
      end
      return status_e'({1'b0, m_state});
    end
    if (!p_enable) return STATUS_NOT_ENABLED;
    n = (p_count > 3'd4) ? 4 : int'(p_count);
    if (n == 0) return STATUS_NOT_INIT;
    for (int i = 0; i < n; i++) begin
      if (p_pair[i][63:32] == key) prim[i] = 1'b1;
      if (m_wait[i] && p_pair[i][31:0] == key) sec = 1'b1;
    end
    if (m_state == MATCH_PRIMARY && sec) begin
      clear_window();
      m_state = MATCH_SECONDARY;
    end else if (prim != '0) begin
      m_wait  = prim;
      m_win   = p_timeout;
      m_run   = 1'b1;
      m_state = MATCH_PRIMARY;
    end else begin
      clear_window();
    end
    return status_e'({1'b0, m_state});
  endfunction

  task automatic send_event(bit func, logic [31:0] key);
    int gap;
    gap = 0;
    if (tx_gap_en && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= key;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    exp_status_q.push_back(next_match_status(func, key));
  endtask

  task automatic send_key(logic [31:0] key);
    send_event(EvKey, key);
  endtask

  task automatic send_tick();
    send_event(EvTick, $urandom);
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (exp_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ENABLE:  p_enable  = val[0];
      REG_TIMEOUT: p_timeout = val[31:0];
      REG_COUNT:   p_count   = val[2:0];
      default:     p_pair[int'(idx) - int'(REG_PATTERN_0)] = val;
    endcase
    @(posedge clk_i);
  endtask

  // result sink with random stalls and an optional long hold-off
  initial begin
    int  n;
    bit  rdy;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
        rdy = 1'b0;
      end else if (rx_stall_en && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 13);
        rdy = 1'b0;
      end else begin
        n = $urandom_range(1, 20);
        rdy = 1'b1;
      end
      m_axis_tready <= rdy;
      repeat (n) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    status_e want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (exp_status_q.size() == 0) begin
        $error("unexpected result, match_status %0d", m_axis_tdata[2:0]);
        err_count++;
      end else begin
        want = exp_status_q.pop_front();
        if (m_axis_tdata[2:0] !== want) begin
          $error("match_status expected %0d actual %0d", want, m_axis_tdata[2:0]);
          err_count++;
        end
        if (m_axis_tdata[7:3] !== 5'd0) begin
          $error("tdata pad expected 0 actual %0d", m_axis_tdata[7:3]);
          err_count++;
        end
      end
    end
  end

  localparam logic [31:0] KeyA = 32'hA5A5_0001;
  localparam logic [31:0] KeyB = 32'h0000_00B1;
  localparam logic [31:0] KeyC = 32'h5A5A_FFC2;

  task automatic test_after_reset();
    send_key(32'h0000_0000);
    send_tick();
    wait_idle();
  endtask

  task automatic test_disabled();
    write_reg(REG_ENABLE, 64'd0);
    write_reg(REG_COUNT, 64'd4);
    write_reg(REG_PATTERN_0, {KeyA, KeyB});
    send_key(KeyA);
    send_tick();
    wait_idle();
    write_reg(REG_ENABLE, 64'd1);
  endtask

  task automatic test_pair_sequences();
    write_reg(REG_TIMEOUT, 64'd2);
    write_reg(REG_PATTERN_1, {KeyA, KeyC});
    write_reg(REG_PATTERN_2, {32'hFFFF_FFFF, 32'h0000_0000});
    write_reg(REG_PATTERN_3, {32'h0000_0000, 32'hFFFF_FFFF});
    // shared primary arms both secondaries
    send_key(KeyA);
    send_key(KeyC);
    send_key(KeyA);
    send_key(KeyB);
    // window expiry, then a stray secondary
    send_key(KeyA);
    send_tick();
    send_tick();
    send_key(KeyB);
    // all-ones / all-zero keys that are both primary and secondary
    send_key(32'hFFFF_FFFF);
    send_key(32'h0000_0000);
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(KeyA);
    send_key(32'h0000_0001);
    wait_idle();
  endtask

  task automatic test_window_extremes();
    write_reg(REG_TIMEOUT, 64'd0);
    send_key(KeyA);
    send_tick();
    wait_idle();
    // count above the pair limit acts as four
    write_reg(REG_TIMEOUT, 64'hFFFF_FFFF);
    write_reg(REG_COUNT, 64'd7);
    send_key(32'h0000_0000);
    send_tick();
    send_key(32'hFFFF_FFFF);
    wait_idle();
    write_reg(REG_COUNT, 64'd1);
    send_key(KeyA);
    send_key(KeyC);
    wait_idle();
  endtask

  function automatic logic [31:0] noise_key();
    case ($urandom_range(0, 3))
      0:       return p_pair[$urandom_range(0, 3)][63:32];
      1:       return p_pair[$urandom_range(0, 3)][31:0];
      default: return $urandom;
    endcase
  endfunction

  // Mostly primary-then-secondary sequences with ticks in between, plus noise.
  task automatic send_random_events(int items);
    int sent;
    int i;
    int ticks;
    int r;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 9) < 7) begin
        i = $urandom_range(0, 3);
        send_key(p_pair[i][63:32]);
        ticks = $urandom_range(0, 4);
        repeat (ticks) send_tick();
        r = $urandom_range(0, 19);
        if (r < 12) send_key(p_pair[i][31:0]);
        else if (r < 17) send_key(p_pair[$urandom_range(0, 3)][31:0]);
        else send_key($urandom);
        sent += 2 + ticks;
      end else begin
        if ($urandom_range(0, 2) == 0) send_tick();
        else send_key(noise_key());
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    tx_gap_en = 1'b0;
    write_reg(REG_COUNT, 64'd4);
    write_reg(REG_TIMEOUT, 64'd3);
    rx_hold_cycles = 300;
    send_random_events(40);
    wait_idle();
    tx_gap_en = 1'b1;
  endtask

  task automatic test_random_phases();
    logic [31:0] key_pool [6];
    logic [63:0] tmo;
    logic [63:0] cnt;
    for (int ph = 0; ph < 9; ph++) begin
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int k = 2; k < 6; k++) key_pool[k] = $urandom;
      case (ph)
        0:       tmo = 64'd0;
        1:       tmo = 64'd1;
        2:       tmo = 64'hFFFF_FFFF;
        default: tmo = 64'($urandom_range(2, 8));
      endcase
      case (ph)
        5:       cnt = 64'd0;
        6:       cnt = 64'($urandom_range(5, 7));
        default: cnt = 64'((ph % 4) + 1);
      endcase
      write_reg(REG_ENABLE, (ph == 4) ? 64'd0 : 64'd1);
      write_reg(REG_TIMEOUT, tmo);
      write_reg(REG_COUNT, cnt);
      for (int k = 0; k < 4; k++) begin
        write_reg(cfg_reg_e'(int'(REG_PATTERN_0) + k),
                  {key_pool[$urandom_range(0, 5)], key_pool[$urandom_range(0, 5)]});
      end
      // no idling on either side in the closing phase
      if (ph == 8) begin
        tx_gap_en   = 1'b0;
        rx_stall_en = 1'b0;
      end
      send_random_events(200);
      wait_idle();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_after_reset();
    test_disabled();
    test_pair_sequences();
    test_window_extremes();
    test_backpressure();
    test_random_phases();
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[key_pair_sequence_matcher] OK");
    end else begin
      $display("[key_pair_sequence_matcher] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/kpsm_pkg.sv
hw/rtl/key_pair_sequence_matcher.sv
sim/key_pair_sequence_matcher_tb.sv
